FILE: design/msgfrag_pkg.sv
// ----------------------------------------------------------------------------
// Message fragmenter package
// Shared types and constants for the message fragmenter.
// ----------------------------------------------------------------------------
package msgfrag_pkg;

    localparam int HDR_BYTES = 12;
    localparam int IDX_W     = 4;

    typedef logic [7:0]       t_byte;
    typedef logic [IDX_W-1:0] t_idx;

    localparam t_idx IDX_FIRST = t_idx'(0);
    localparam t_idx IDX_LAST  = t_idx'(HDR_BYTES);

endpackage

FILE: design/msgfrag_if.sv
// ----------------------------------------------------------------------------
// Message fragmenter channels
// Valid/ready interfaces for the content input and the packet byte output.
// ----------------------------------------------------------------------------
interface msgfrag_in_if;
    logic                 valid;
    logic                 ready;
    msgfrag_pkg::t_byte   content_byte;
    logic [31:0]          req_id;
    logic [15:0]          message_length;

    modport source (output valid, output content_byte, output req_id,
                    output message_length, input ready);
    modport sink   (input valid, input content_byte, input req_id,
                    input message_length, output ready);
endinterface

interface msgfrag_out_if;
    logic                 valid;
    logic                 ready;
    msgfrag_pkg::t_byte   out_byte;
    logic                 packet_end;
    logic                 message_end;
    logic                 run_last;

    modport source (output valid, output out_byte, output packet_end,
                    output message_end, output run_last, input ready);
    modport sink   (input valid, input out_byte, input packet_end,
                    input message_end, input run_last, output ready);
endinterface

FILE: design/message_fragmenter_unit.sv
// ----------------------------------------------------------------------------
// Message fragmenter
// Cuts a byte stream into packets, each led by a 12-byte header.
// ----------------------------------------------------------------------------
// Content bytes enter on i_in together with the request id and the total
// length, which are sampled on the first byte of each message. Bytes leave on
// o_out. A byte that opens a packet produces 13 output items: the header
// (request id, length and fragment number, 4 bytes each, most significant
// first) and then the byte itself; any other byte produces one item.
// Packet and message end flags mark the last payload byte, and run_last marks
// the last item caused by each input item.
// An accepted item is shown on o_out in the next cycle. The output sequencer
// sends one byte per cycle while o_out.ready is high, and the next input item
// is taken in the same cycle as the last byte of the current one leaves.
// If the receiver stalls, the current byte holds and i_in.ready stays low
// until its last byte is taken. Reset empties the output register and
// returns the block to the start of a new message.
// ----------------------------------------------------------------------------
module message_fragmenter_unit #(
    parameter int CHUNK_BYTES       = 512,
    parameter int MAX_MESSAGE_BYTES = 65535
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    msgfrag_in_if.sink           i_in,
    msgfrag_out_if.source        o_out
);

    localparam int CW = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1;
    localparam logic [CW-1:0] CHUNK_LAST = CW'(CHUNK_BYTES - 1);
    localparam logic [31:0]   MAX_LEN    = 32'(MAX_MESSAGE_BYTES);

    logic [15:0]         r_byte_position;
    logic [15:0]         r_fragment_count;
    logic [CW-1:0]       r_chunk_pos;
    logic [31:0]         r_held_request;
    logic [15:0]         r_held_length;

    logic                r_busy;
    msgfrag_pkg::t_idx   r_idx;
    logic [31:0]         r_req;
    logic [15:0]         r_len;
    logic [15:0]         r_frag;
    msgfrag_pkg::t_byte  r_byte;
    logic                r_pend;
    logic                r_mend;

    logic [31:0]         n_held_request;
    logic [15:0]         n_held_length;
    logic [15:0]         n_eff_len;
    logic                n_mend;
    logic                n_pend;
    logic                n_hdr;

    logic                w_last;
    logic                w_in_fire;
    logic                w_out_fire;
    msgfrag_pkg::t_byte  w_hdr_bytes [msgfrag_pkg::HDR_BYTES];

    assign w_last     = r_busy && (r_idx == msgfrag_pkg::IDX_LAST);
    assign i_in.ready = !r_busy || (w_last && o_out.ready);
    assign w_in_fire  = i_in.valid && i_in.ready;
    assign w_out_fire = o_out.valid && o_out.ready;

    always_comb begin
        if (r_byte_position == 16'd0) begin
            n_held_request = i_in.req_id;
            n_held_length  = i_in.message_length;
        end else begin
            n_held_request = r_held_request;
            n_held_length  = r_held_length;
        end
        if ({16'd0, n_held_length} > MAX_LEN) begin
            n_eff_len = MAX_LEN[15:0];
        end else begin
            n_eff_len = n_held_length;
        end
        if (n_eff_len == 16'd0) begin
            n_eff_len = 16'd1;
        end
        n_hdr  = (r_chunk_pos == '0);
        n_mend = ({1'b0, r_byte_position} + 17'd1) >= {1'b0, n_eff_len};
        n_pend = n_mend || (r_chunk_pos == CHUNK_LAST);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy           <= 1'b0;
            r_byte_position  <= '0;
            r_fragment_count <= '0;
            r_chunk_pos      <= '0;
            r_held_request   <= '0;
            r_held_length    <= '0;
        end else if (w_in_fire) begin
            r_busy         <= 1'b1;
            r_held_request <= n_held_request;
            r_held_length  <= n_held_length;
            if (n_mend) begin
                r_byte_position  <= '0;
                r_fragment_count <= '0;
                r_chunk_pos      <= '0;
            end else begin
                r_byte_position <= r_byte_position + 16'd1;
                if (n_pend) begin
                    r_fragment_count <= r_fragment_count + 16'd1;
                    r_chunk_pos      <= '0;
                end else begin
                    r_chunk_pos <= r_chunk_pos + CW'(1);
                end
            end
        end else if (w_out_fire && w_last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_idx  <= n_hdr ? msgfrag_pkg::IDX_FIRST : msgfrag_pkg::IDX_LAST;
            r_req  <= n_held_request;
            r_len  <= n_held_length;
            r_frag <= r_fragment_count;
            r_byte <= i_in.content_byte;
            r_pend <= n_pend;
            r_mend <= n_mend;
        end else if (w_out_fire && !w_last) begin
            r_idx <= r_idx + msgfrag_pkg::t_idx'(1);
        end
    end

    assign w_hdr_bytes[0]  = r_req[31:24];
    assign w_hdr_bytes[1]  = r_req[23:16];
    assign w_hdr_bytes[2]  = r_req[15:8];
    assign w_hdr_bytes[3]  = r_req[7:0];
    assign w_hdr_bytes[4]  = 8'd0;
    assign w_hdr_bytes[5]  = 8'd0;
    assign w_hdr_bytes[6]  = r_len[15:8];
    assign w_hdr_bytes[7]  = r_len[7:0];
    assign w_hdr_bytes[8]  = 8'd0;
    assign w_hdr_bytes[9]  = 8'd0;
    assign w_hdr_bytes[10] = r_frag[15:8];
    assign w_hdr_bytes[11] = r_frag[7:0];

    always_comb begin
        if (r_idx < msgfrag_pkg::IDX_LAST) begin
            o_out.out_byte = w_hdr_bytes[r_idx];
        end else begin
            o_out.out_byte = r_byte;
        end
    end

    assign o_out.valid       = r_busy;
    assign o_out.run_last    = (r_idx == msgfrag_pkg::IDX_LAST);
    assign o_out.packet_end  = o_out.run_last && r_pend;
    assign o_out.message_end = o_out.run_last && r_mend;

endmodule

FILE: design/msgfrag_checker.sv
// ----------------------------------------------------------------------------
// Message fragmenter checker
// Port-level assertions on the output stream of the message fragmenter.
// ----------------------------------------------------------------------------
module msgfrag_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [7:0]  i_out_byte,
    input  logic        i_packet_end,
    input  logic        i_message_end,
    input  logic        i_run_last
);

    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("Output valid right after reset.");

    a_stall_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_byte)
            && $stable(i_run_last) && $stable(i_packet_end))
        else $error("Stalled output item changed.");

    a_header_flags : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_run_last |-> !i_packet_end && !i_message_end)
        else $error("End flag set on a header byte.");

    a_msg_ends_pkt : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_message_end |-> i_packet_end && i_run_last)
        else $error("Message end without packet end.");

    a_header_runs : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_run_last |=> i_out_valid)
        else $error("Header burst broken off.");

endmodule

bind message_fragmenter_unit msgfrag_checker u_msgfrag_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_byte    (o_out.out_byte),
    .i_packet_end  (o_out.packet_end),
    .i_message_end (o_out.message_end),
    .i_run_last    (o_out.run_last)
);
